FILE: hdl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; used by the digit cell, the digit chain and the top level.
`default_nettype none

package sida_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 19;  // 2^63 has 19 decimal digits
    localparam int DIGIT_W    = 4;
    localparam int LEN_W      = 5;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef logic [DIGIT_W-1:0] digit_t;

    // Command to every cell of the row; clear wins over dabble, dabble over shift.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii_unit.sv
// Signed 64-bit integer to decimal ASCII, one character per output transfer.
// After the input transfer: shift-add-3 through the digit cell row, then dropping
// leading zeros, then entering emit and loading the output register.
// Input is held off until the last character is loaded. Reset clears the control
// state and the digit cells, not the magnitude, sign, length or output data registers.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [sida_pkg::VALUE_W-1:0]   value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [sida_pkg::CHAR_W-1:0]                character,
    output logic [sida_pkg::LEN_W-1:0]                 text_length,
    output logic                                       last
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CONVERT = 4'b0010,
        ST_SKIP    = 4'b0100,
        ST_EMIT    = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [sida_pkg::VALUE_W-1:0]     mag_reg, mag_next;
    logic [sida_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             neg_reg, neg_next;
    logic                             sign_pend_reg, sign_pend_next;
    logic [sida_pkg::LEN_W-1:0]       left_reg, left_next;
    logic [sida_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                             out_valid_reg, out_valid_next;
    logic [sida_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic [sida_pkg::LEN_W-1:0]       olen_reg, olen_next;
    logic                             last_reg, last_next;

    sida_pkg::cell_ctrl_t             ctrl;
    sida_pkg::digit_t                 top_digit;
    logic                             out_load;
    logic                             in_xfer;

    sida_digit_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .bit_in    (mag_reg[sida_pkg::VALUE_W-1]),
        .top_digit (top_digit)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        left_next      = left_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        olen_next      = olen_reg;
        last_next      = last_reg;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next   = value[sida_pkg::VALUE_W-1];
                    // negation of the most negative value wraps to 2^63, as wanted
                    mag_next   = value[sida_pkg::VALUE_W-1] ? -value : value;
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.dabble = 1'b1;
                mag_next    = {mag_reg[sida_pkg::VALUE_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == sida_pkg::CNT_W'(sida_pkg::VALUE_W - 1))
                begin
                    left_next  = sida_pkg::LEN_W'(sida_pkg::NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if (top_digit == '0 && left_reg > sida_pkg::LEN_W'(1))
                begin
                    ctrl.shift = 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                else
                begin
                    len_next       = left_reg + sida_pkg::LEN_W'(neg_reg);
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    olen_next      = len_reg;
                    if (sign_pend_reg)
                    begin
                        char_next      = sida_pkg::CHAR_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next  = sida_pkg::CHAR_ZERO | sida_pkg::CHAR_W'(top_digit);
                        last_next  = (left_reg == sida_pkg::LEN_W'(1));
                        ctrl.shift = 1'b1;
                        left_next  = left_reg - 1'b1;
                        if (left_reg == sida_pkg::LEN_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sign_pend_reg <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sign_pend_reg <= sign_pend_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        len_reg  <= len_next;
        char_reg <= char_next;
        olen_reg <= olen_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign character   = char_reg;
    assign text_length = olen_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

FILE: hdl/sida_digit_cell.sv
// One BCD digit cell: add-3-and-shift step, digit shift toward the top, clear.
// Depends on sida_pkg.
`default_nettype none

module sida_digit_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sida_pkg::cell_ctrl_t ctrl,
    input  wire logic                 carry_in,
    input  wire sida_pkg::digit_t     digit_in,
    output sida_pkg::digit_t          digit,
    output logic                      carry_out
);

    sida_pkg::digit_t digit_reg;
    sida_pkg::digit_t digit_next;
    sida_pkg::digit_t adj;

    // correct before the shift so the digit never exceeds nine afterwards
    assign adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit     = digit_reg;
    assign carry_out = adj[3];

endmodule

`default_nettype wire

FILE: hdl/sida_digit_chain.sv
// Row of BCD digit cells, least significant at index 0. Bits enter at the
// bottom during conversion; digits move toward the top when zeros are dropped and when emitted.
// Depends on sida_pkg and sida_digit_cell.
`default_nettype none

module sida_digit_chain (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sida_pkg::cell_ctrl_t ctrl,
    input  wire logic                 bit_in,
    output sida_pkg::digit_t          top_digit
);

    sida_pkg::digit_t digits [sida_pkg::NUM_DIGITS];
    logic [sida_pkg::NUM_DIGITS-2:0] carry;

    for (genvar i = 0; i < sida_pkg::NUM_DIGITS; i++)
    begin : g_cell
        logic             c_in;
        sida_pkg::digit_t d_in;

        if (i == 0)
        begin : g_bottom
            assign c_in = bit_in;
            assign d_in = '0;
        end
        else
        begin : g_upper
            assign c_in = carry[i-1];
            assign d_in = digits[i-1];
        end

        if (i < sida_pkg::NUM_DIGITS - 1)
        begin : g_mid
            sida_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (c_in),
                .digit_in  (d_in),
                .digit     (digits[i]),
                .carry_out (carry[i])
            );
        end
        else
        begin : g_top
            // the top digit never produces a carry for a magnitude of at most 2^63
            sida_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (c_in),
                .digit_in  (d_in),
                .digit     (digits[i]),
                .carry_out ()
            );
        end
    end

    assign top_digit = digits[sida_pkg::NUM_DIGITS-1];

endmodule

`default_nettype wire

FILE: test/tb_signed_int_to_decimal_ascii_unit.sv
// Testbench for signed_int_to_decimal_ascii_unit: random and directed 64-bit values in,
// decimal ASCII characters out, checked against a scoreboard that renders each value.
// Depends on sida_pkg and the unit's RTL only.
`default_nettype none

module tb_signed_int_to_decimal_ascii_unit;
    import sida_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              fin;
    } text_char_t;

    class decimal_text_board;
        text_char_t pending_chars[$];
        int         mismatches = 0;

        // Render the value as decimal text and queue one entry per character.
        function void note_input(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            logic [CHAR_W-1:0]  d;
            logic [CHAR_W-1:0]  txt[$];
            logic               neg;
            int                 total;
            text_char_t         e;
            neg = v[VALUE_W-1];
            mag = neg ? (~v + 64'd1) : v;
            do
            begin
                d = CHAR_W'(mag % 64'd10);
                txt.push_front(CHAR_ZERO + d);
                mag = mag / 64'd10;
            end
            while (mag != 0);
            if (neg)
                txt.push_front(CHAR_MINUS);
            total = txt.size();
            foreach (txt[i])
            begin
                e.ch  = txt[i];
                e.len = total[LEN_W-1:0];
                e.fin = (i == total - 1);
                pending_chars.push_back(e);
            end
        endfunction

        function void check_result(logic [CHAR_W-1:0] ch, logic [LEN_W-1:0] len, logic fin);
            text_char_t e;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transfer: character %h text_length %0d last %b",
                       ch, len, fin);
                mismatches++;
                return;
            end
            e = pending_chars.pop_front();
            if (ch !== e.ch)
            begin
                $error("character: expected %h, got %h", e.ch, ch);
                mismatches++;
            end
            if (len !== e.len)
            begin
                $error("text_length: expected %0d, got %0d", e.len, len);
                mismatches++;
            end
            if (fin !== e.fin)
            begin
                $error("last: expected %b, got %b", e.fin, fin);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         character;
    logic [LEN_W-1:0]          text_length;
    logic                      last;

    decimal_text_board board = new();
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                hold_request = 1'b0;
    int                cycles = 0;

    signed_int_to_decimal_ascii_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .character   (character),
        .text_length (text_length),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL signed_int_to_decimal_ascii_unit");
            $finish;
        end
    end

    // Receiver: check each character transfer, then pick ready for the next edge.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                board.check_result(character, text_length, last);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(v);
    endtask

    // Hold the input idle until every queued character has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // Mix of full-width values, short magnitudes and values around powers of ten.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] r;
        logic [VALUE_W-1:0] p;
        int                 kind;
        int                 w;
        r = {$urandom, $urandom};
        kind = $urandom_range(9);
        if (kind < 4)
            return r;
        if (kind < 7)
        begin
            w = $urandom_range(63, 1);
            r = r & ((64'd1 << w) - 64'd1);
        end
        else
        begin
            p = 64'd1;
            repeat ($urandom_range(18))
                p = p * 64'd10;
            r = p + $urandom_range(2) - 64'd1;
        end
        if ($urandom_range(1))
            r = -r;
        return r;
    endfunction

    initial
    begin
        logic [VALUE_W-1:0] directed[$];
        directed = '{
            64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100, -64'sd101,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
            64'd1000000000000000000, 64'd999999999999999999, -64'sd1000000000000000000,
            64'd2147483647, -64'sd2147483648, 64'd4294967295, 64'd1234567890123456789,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
        };

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i]);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 30 : 0;
            // Stall the output for a long stretch so the unit backs up into its input.
            if (phase == 2)
                hold_request = 1'b1;
            repeat (46)
                send_value(pick_value());
            wait_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("PASS signed_int_to_decimal_ascii_unit");
        else
            $display("FAIL signed_int_to_decimal_ascii_unit");
        $finish;
    end

endmodule

`default_nettype wire
